@@ sv/assert_macros.svh @@
// Shared assertion shorthands, clocked on the rising edge and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ece_pkg.sv @@
package ece_pkg;

    localparam int FRAC_BITS = 16;
    localparam int KIND_W    = 5;
    localparam int PROG_W    = FRAC_BITS + 1;
    localparam int DATA_W    = 38;
    localparam int NUM_REGS  = 4;
    localparam int NUM_CELLS = 28;
    localparam int IDX_W     = $clog2(NUM_CELLS);

    localparam logic [KIND_W-1:0] KIND_LINEAR  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_SMOOTH  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_SMOOTH5 = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_SMOOTH7 = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_COS_IO  = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_SIN_IN  = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_SIN_OUT = KIND_W'(6);
    localparam logic [KIND_W-1:0] KIND_LAST    = KIND_W'(18);

    localparam logic [PROG_W-1:0] ONE_FB = PROG_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] ONE31  = DATA_W'(64'd1 << 31);
    localparam logic [DATA_W-1:0] HALF31 = DATA_W'(64'd1 << 30);
    localparam logic [DATA_W-1:0] RND31  = DATA_W'(64'd1 << (30 - FRAC_BITS));

    localparam logic [DATA_W-1:0] M_272 = DATA_W'((64'd1 << 34) / 64'd272);
    localparam logic [DATA_W-1:0] M_210 = DATA_W'((64'd1 << 34) / 64'd210);
    localparam logic [DATA_W-1:0] M_156 = DATA_W'((64'd1 << 34) / 64'd156);
    localparam logic [DATA_W-1:0] M_110 = DATA_W'((64'd1 << 34) / 64'd110);
    localparam logic [DATA_W-1:0] M_72  = DATA_W'((64'd1 << 34) / 64'd72);
    localparam logic [DATA_W-1:0] M_42  = DATA_W'((64'd1 << 34) / 64'd42);
    localparam logic [DATA_W-1:0] M_20  = DATA_W'((64'd1 << 34) / 64'd20);
    localparam logic [DATA_W-1:0] M_6   = DATA_W'((64'd1 << 34) / 64'd6);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_MULCAP,
        OP_KSUB,
        OP_RECIP,
        OP_CORR
    } op_t;

    typedef enum logic [2:0] {
        SEL_R0,
        SEL_R1,
        SEL_R2,
        SEL_R3,
        SEL_K
    } sel_t;

    typedef enum logic [4:0] {
        K_ZERO, K_ONE, K_2, K_3, K_6, K_10, K_15, K_20, K_35, K_70, K_84, K_PIH,
        K_M0, K_M1, K_M2, K_M3, K_M4, K_M5, K_M6, K_M7,
        K_D0, K_D1, K_D2, K_D3, K_D4, K_D5, K_D6, K_D7
    } kidx_t;

    typedef enum logic [2:0] {
        FIN_PLAIN,
        FIN_MIRROR,
        FIN_DOUBLE,
        FIN_INV,
        FIN_HALF,
        FIN_HALF_INV
    } fin_t;

    typedef enum logic [1:0] {
        DIR_IN,
        DIR_OUT,
        DIR_INOUT
    } dir_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] dst;
        sel_t       sa;
        sel_t       sb;
        kidx_t      ka;
        kidx_t      kb;
        kidx_t      kc;
    } instr_t;

    typedef struct packed {
        logic [KIND_W-1:0]                   kind;
        logic                                err;
        logic                                zero;
        logic                                one;
        fin_t                                fin;
        logic [NUM_REGS-1:0][DATA_W-1:0]     r;
    } stage_t;

    localparam kidx_t SIN_RECIP [8] = '{K_M0, K_M1, K_M2, K_M3, K_M4, K_M5, K_M6, K_M7};
    localparam kidx_t SIN_DIV   [8] = '{K_D0, K_D1, K_D2, K_D3, K_D4, K_D5, K_D6, K_D7};

    function automatic logic [DATA_W-1:0] kval(kidx_t k);
        logic [DATA_W-1:0] v;
        unique case (k)
            K_ZERO:  v = '0;
            K_ONE:   v = ONE31;
            K_2:     v = DATA_W'(64'd2 << 31);
            K_3:     v = DATA_W'(64'd3 << 31);
            K_6:     v = DATA_W'(64'd6 << 31);
            K_10:    v = DATA_W'(64'd10 << 31);
            K_15:    v = DATA_W'(64'd15 << 31);
            K_20:    v = DATA_W'(64'd20 << 31);
            K_35:    v = DATA_W'(64'd35 << 31);
            K_70:    v = DATA_W'(64'd70 << 31);
            K_84:    v = DATA_W'(64'd84 << 31);
            K_PIH:   v = DATA_W'(64'hC90FDAA2);
            K_M0:    v = M_272;
            K_M1:    v = M_210;
            K_M2:    v = M_156;
            K_M3:    v = M_110;
            K_M4:    v = M_72;
            K_M5:    v = M_42;
            K_M6:    v = M_20;
            K_M7:    v = M_6;
            K_D0:    v = DATA_W'(272);
            K_D1:    v = DATA_W'(210);
            K_D2:    v = DATA_W'(156);
            K_D3:    v = DATA_W'(110);
            K_D4:    v = DATA_W'(72);
            K_D5:    v = DATA_W'(42);
            K_D6:    v = DATA_W'(20);
            K_D7:    v = DATA_W'(6);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pow_order(logic [KIND_W-1:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_W'(7), KIND_W'(8), KIND_W'(9):    n = 3'd2;
            KIND_W'(10), KIND_W'(11), KIND_W'(12): n = 3'd3;
            KIND_W'(13), KIND_W'(14), KIND_W'(15): n = 3'd4;
            KIND_W'(16), KIND_W'(17), KIND_W'(18): n = 3'd5;
            default:                               n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic dir_t pow_dir(logic [KIND_W-1:0] kind);
        dir_t d;
        unique case (kind)
            KIND_W'(7), KIND_W'(10), KIND_W'(13), KIND_W'(16): d = DIR_IN;
            KIND_W'(8), KIND_W'(11), KIND_W'(14), KIND_W'(17): d = DIR_OUT;
            default:                                           d = DIR_INOUT;
        endcase
        return d;
    endfunction

    function automatic instr_t mk(op_t op, logic [1:0] dst, sel_t sa, sel_t sb,
                                  kidx_t ka, kidx_t kb, kidx_t kc);
        instr_t ins;
        ins.op  = op;
        ins.dst = dst;
        ins.sa  = sa;
        ins.sb  = sb;
        ins.ka  = ka;
        ins.kb  = kb;
        ins.kc  = kc;
        return ins;
    endfunction

    // Per-kind program: the operation that cell idx applies.
    function automatic instr_t prog(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
        instr_t ins;
        ins = mk(OP_NOP, 2'd0, SEL_R0, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
        if (kind == KIND_SMOOTH) begin
            if (idx == IDX_W'(0))
                ins = mk(OP_MUL, 2'd2, SEL_R0, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(1))
                ins = mk(OP_KSUB, 2'd3, SEL_K, SEL_R0, K_2, K_ZERO, K_3);
            else if (idx == IDX_W'(2))
                ins = mk(OP_MUL, 2'd1, SEL_R3, SEL_R2, K_ZERO, K_ZERO, K_ZERO);
        end else if (kind == KIND_SMOOTH5) begin
            if (idx == IDX_W'(0))
                ins = mk(OP_MUL, 2'd2, SEL_R0, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(1))
                ins = mk(OP_MUL, 2'd2, SEL_R2, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(2))
                ins = mk(OP_KSUB, 2'd3, SEL_K, SEL_R0, K_6, K_ZERO, K_15);
            else if (idx == IDX_W'(3))
                ins = mk(OP_KSUB, 2'd3, SEL_R3, SEL_R0, K_ZERO, K_ZERO, K_10);
            else if (idx == IDX_W'(4))
                ins = mk(OP_MUL, 2'd1, SEL_R3, SEL_R2, K_ZERO, K_ZERO, K_ZERO);
        end else if (kind == KIND_SMOOTH7) begin
            if (idx == IDX_W'(0))
                ins = mk(OP_MUL, 2'd2, SEL_R0, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(1))
                ins = mk(OP_MUL, 2'd2, SEL_R2, SEL_R2, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(2))
                ins = mk(OP_KSUB, 2'd3, SEL_K, SEL_R0, K_20, K_ZERO, K_70);
            else if (idx == IDX_W'(3))
                ins = mk(OP_KSUB, 2'd3, SEL_R3, SEL_R0, K_ZERO, K_ZERO, K_84);
            else if (idx == IDX_W'(4))
                ins = mk(OP_KSUB, 2'd3, SEL_R3, SEL_R0, K_ZERO, K_ZERO, K_35);
            else if (idx == IDX_W'(5))
                ins = mk(OP_MUL, 2'd1, SEL_R3, SEL_R2, K_ZERO, K_ZERO, K_ZERO);
        end else if (kind == KIND_COS_IO || kind == KIND_SIN_IN || kind == KIND_SIN_OUT) begin
            if (idx == IDX_W'(0))
                ins = mk(OP_MUL, 2'd0, SEL_R0, SEL_K, K_ZERO, K_PIH, K_ZERO);
            else if (idx == IDX_W'(1))
                ins = mk(OP_MUL, 2'd2, SEL_R0, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(26))
                ins = mk(OP_MULCAP, 2'd1, SEL_R0, SEL_R1, K_ZERO, K_ZERO, K_ZERO);
            else if (idx == IDX_W'(27)) begin
                if (kind != KIND_SIN_OUT)
                    ins = mk(OP_MUL, 2'd1, SEL_R1, SEL_R1, K_ZERO, K_ZERO, K_ZERO);
            end else begin
                for (int i = 0; i < 8; i++) begin
                    if (idx == IDX_W'(2 + 3 * i))
                        ins = mk(OP_MUL, 2'd3, SEL_R2, SEL_R1, K_ZERO, K_ZERO, K_ZERO);
                    else if (idx == IDX_W'(3 + 3 * i))
                        ins = mk(OP_RECIP, 2'd1, SEL_R3, SEL_K, K_ZERO, SIN_RECIP[i],
                                 K_ZERO);
                    else if (idx == IDX_W'(4 + 3 * i))
                        ins = mk(OP_CORR, 2'd1, SEL_R3, SEL_R1, K_ZERO, SIN_DIV[i],
                                 K_ZERO);
                end
            end
        end else if (kind > KIND_SIN_OUT && kind <= KIND_LAST) begin
            if ({1'b0, idx} < (IDX_W + 1)'(pow_order(kind) - 3'd1))
                ins = mk(OP_MUL, 2'd1, SEL_R1, SEL_R0, K_ZERO, K_ZERO, K_ZERO);
        end
        return ins;
    endfunction

endpackage

@@ sv/ece_if.sv @@
interface ece_req_if;
    logic                           valid;
    logic                           ready;
    logic [ece_pkg::KIND_W-1:0]     curve_kind;
    logic [ece_pkg::PROG_W-1:0]     progress;

    modport source (output valid, output curve_kind, output progress, input ready);
    modport sink   (input valid, input curve_kind, input progress, output ready);
endinterface

interface ece_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ece_pkg::PROG_W-1:0]     eased_value;
    logic                           range_error;

    modport source (output valid, output eased_value, output range_error, input ready);
    modport sink   (input valid, input eased_value, input range_error, output ready);
endinterface

@@ sv/ece_front.sv @@
module ece_front (
    input  logic [ece_pkg::KIND_W-1:0] curve_kind,
    input  logic [ece_pkg::PROG_W-1:0] progress,
    output ece_pkg::stage_t            stage
);

    logic [ece_pkg::DATA_W-1:0] t;

    assign t = ece_pkg::DATA_W'(progress) << (31 - ece_pkg::FRAC_BITS);

    always_comb
    begin
        stage      = '0;
        stage.kind = curve_kind;
        stage.err  = (curve_kind > ece_pkg::KIND_LAST) || (progress > ece_pkg::ONE_FB);
        stage.zero = (progress == '0);
        stage.one  = (progress == ece_pkg::ONE_FB);
        stage.fin  = ece_pkg::FIN_PLAIN;
        if (curve_kind == ece_pkg::KIND_LINEAR)
        begin
            stage.r[1] = t;
        end
        else if (curve_kind <= ece_pkg::KIND_SMOOTH7)
        begin
            if (t > ece_pkg::HALF31)
            begin
                stage.r[0] = ece_pkg::ONE31 - t;
                stage.fin  = ece_pkg::FIN_MIRROR;
            end
            else
            begin
                stage.r[0] = t;
            end
        end
        else if (curve_kind <= ece_pkg::KIND_SIN_OUT)
        begin
            stage.r[1] = ece_pkg::ONE31;
            if (curve_kind == ece_pkg::KIND_SIN_IN)
            begin
                stage.r[0] = t >> 1;
                stage.fin  = ece_pkg::FIN_DOUBLE;
            end
            else
            begin
                stage.r[0] = t;
            end
        end
        else
        begin
            unique case (ece_pkg::pow_dir(curve_kind))
                ece_pkg::DIR_IN:
                begin
                    stage.r[0] = t;
                end
                ece_pkg::DIR_OUT:
                begin
                    stage.r[0] = ece_pkg::ONE31 - t;
                    stage.fin  = ece_pkg::FIN_INV;
                end
                default:
                begin
                    if (t < ece_pkg::HALF31)
                    begin
                        stage.r[0] = t << 1;
                        stage.fin  = ece_pkg::FIN_HALF;
                    end
                    else
                    begin
                        stage.r[0] = (ece_pkg::ONE31 - t) << 1;
                        stage.fin  = ece_pkg::FIN_HALF_INV;
                    end
                end
            endcase
            stage.r[1] = stage.r[0];
        end
    end

endmodule

@@ sv/ece_cell.sv @@
module ece_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [ece_pkg::IDX_W-1:0]  idx,
    input  logic                       in_valid,
    input  ece_pkg::stage_t            in_stage,
    output logic                       out_valid,
    output ece_pkg::stage_t            out_stage
);

    ece_pkg::instr_t             ins;
    logic [ece_pkg::DATA_W-1:0]  a;
    logic [ece_pkg::DATA_W-1:0]  b_full;
    logic [32:0]                 b;
    logic [6:0]                  a_hi;
    logic [30:0]                 a_lo;
    logic [39:0]                 hi_prod;
    logic [63:0]                 lo_prod;
    logic [40:0]                 sum;
    logic [ece_pkg::DATA_W-1:0]  prod;
    logic [8:0]                  div;
    logic [41:0]                 qd;
    logic [ece_pkg::DATA_W-1:0]  rem;
    logic [ece_pkg::DATA_W-1:0]  quo;
    logic [ece_pkg::DATA_W-1:0]  res;
    logic                        valid_reg;
    logic                        valid_next;
    ece_pkg::stage_t             stage_reg;
    ece_pkg::stage_t             stage_next;

    function automatic logic [ece_pkg::DATA_W-1:0] pick(ece_pkg::sel_t sel,
                                                        ece_pkg::kidx_t k,
                                                        ece_pkg::stage_t st);
        logic [ece_pkg::DATA_W-1:0] v;
        unique case (sel)
            ece_pkg::SEL_R0: v = st.r[0];
            ece_pkg::SEL_R1: v = st.r[1];
            ece_pkg::SEL_R2: v = st.r[2];
            ece_pkg::SEL_R3: v = st.r[3];
            default:         v = ece_pkg::kval(k);
        endcase
        return v;
    endfunction

    assign ins     = ece_pkg::prog(in_stage.kind, idx);
    assign a       = pick(ins.sa, ins.ka, in_stage);
    assign b_full  = pick(ins.sb, ins.kb, in_stage);
    assign b       = b_full[32:0];
    assign a_hi    = a[ece_pkg::DATA_W-1:31];
    assign a_lo    = a[30:0];
    assign hi_prod = 40'(a_hi) * 40'(b);
    assign lo_prod = 64'(a_lo) * 64'(b);
    assign sum     = 41'(hi_prod) + 41'(lo_prod[63:31]);
    assign prod    = sum[ece_pkg::DATA_W-1:0];

    // Constant division: estimate from the reciprocal, then fix up by at most one.
    assign div = ece_pkg::kval(ins.kb)[8:0];
    assign qd  = 42'(b) * 42'(div);
    assign rem = a - qd[ece_pkg::DATA_W-1:0];
    assign quo = ece_pkg::DATA_W'(b) +
                 ece_pkg::DATA_W'(rem >= ece_pkg::DATA_W'(div));

    always_comb
    begin
        unique case (ins.op)
            ece_pkg::OP_MUL:    res = prod;
            ece_pkg::OP_MULCAP: res = (prod > ece_pkg::ONE31) ? ece_pkg::ONE31 : prod;
            ece_pkg::OP_KSUB:   res = ece_pkg::kval(ins.kc) - prod;
            ece_pkg::OP_RECIP:  res = prod >> 3;
            ece_pkg::OP_CORR:   res = ece_pkg::ONE31 - quo;
            default:            res = '0;
        endcase
        stage_next = in_stage;
        if (ins.op != ece_pkg::OP_NOP)
        begin
            stage_next.r[ins.dst] = res;
        end
        valid_next = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

@@ sv/ece_out.sv @@
module ece_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  ece_pkg::stage_t            in_stage,
    output logic                       valid,
    output logic [ece_pkg::PROG_W-1:0] eased_value,
    output logic                       range_error
);

    logic [ece_pkg::DATA_W-1:0] v;
    logic [ece_pkg::DATA_W-1:0] lower;
    logic [ece_pkg::DATA_W-1:0] shaped;
    logic [ece_pkg::DATA_W-1:0] capped;
    logic [ece_pkg::DATA_W-1:0] rounded;
    logic [ece_pkg::PROG_W-1:0] val;
    logic                       valid_reg;
    logic                       valid_next;
    logic [ece_pkg::PROG_W-1:0] value_reg;
    logic [ece_pkg::PROG_W-1:0] value_next;
    logic                       err_reg;
    logic                       err_next;

    assign v     = in_stage.r[1];
    assign lower = (v > ece_pkg::ONE31) ? ece_pkg::ONE31 : v;

    always_comb
    begin
        unique case (in_stage.fin)
            ece_pkg::FIN_MIRROR:   shaped = ece_pkg::ONE31 - lower;
            ece_pkg::FIN_DOUBLE:   shaped = v << 1;
            ece_pkg::FIN_INV:      shaped = ece_pkg::ONE31 - v;
            ece_pkg::FIN_HALF:     shaped = v >> 1;
            ece_pkg::FIN_HALF_INV: shaped = ece_pkg::ONE31 - (v >> 1);
            default:               shaped = v;
        endcase
        capped  = (shaped > ece_pkg::ONE31) ? ece_pkg::ONE31 : shaped;
        rounded = (capped + ece_pkg::RND31) >> (31 - ece_pkg::FRAC_BITS);
        val     = (rounded > ece_pkg::DATA_W'(ece_pkg::ONE_FB)) ? ece_pkg::ONE_FB
                                                                : rounded[ece_pkg::PROG_W-1:0];
        priority if (in_stage.err)
        begin
            value_next = '0;
        end
        else if (in_stage.zero)
        begin
            value_next = '0;
        end
        else if (in_stage.one)
        begin
            value_next = ece_pkg::ONE_FB;
        end
        else
        begin
            value_next = val;
        end
        err_next   = in_stage.err;
        valid_next = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign valid       = valid_reg;
    assign eased_value = value_reg;
    assign range_error = err_reg;

endmodule

@@ sv/easing_curve_evaluator_top.sv @@
// Pipeline: 28 cells plus the output register between an accepted request and its result.
// Throughput: one request per cycle while the cell chain advances, which it does whenever the output is free or taken.
// Every curve walks the full chain; the sine series sets its length.
// Reset: rst_n clears all valid flags asynchronously; no clearing pass, ready right after reset.
`include "assert_macros.svh"

module easing_curve_evaluator_top (
    input  logic        clk,
    input  logic        rst_n,
    ece_req_if.sink     req,
    ece_rsp_if.source   rsp
);

    logic                              adv;
    logic [ece_pkg::NUM_CELLS:0]       chain_valid;
    ece_pkg::stage_t                   chain_stage [ece_pkg::NUM_CELLS+1];

    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;
    assign chain_valid[0] = req.valid;

    ece_front u_front (
        .curve_kind (req.curve_kind),
        .progress   (req.progress),
        .stage      (chain_stage[0])
    );

    for (genvar g = 0; g < ece_pkg::NUM_CELLS; g++)
    begin : g_cell
        ece_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .idx       (ece_pkg::IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_stage  (chain_stage[g]),
            .out_valid (chain_valid[g+1]),
            .out_stage (chain_stage[g+1])
        );
    end

    ece_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (chain_valid[ece_pkg::NUM_CELLS]),
        .in_stage    (chain_stage[ece_pkg::NUM_CELLS]),
        .valid       (rsp.valid),
        .eased_value (rsp.eased_value),
        .range_error (rsp.range_error)
    );

    `ASSERT_IMPL(a_err_zero, clk, rst_n, rsp.valid && rsp.range_error, rsp.eased_value == '0)
    `ASSERT_IMPL(a_val_max, clk, rst_n, rsp.valid, rsp.eased_value <= ece_pkg::ONE_FB)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(chain_valid[ece_pkg::NUM_CELLS:1]))

endmodule

@@ verif/tb_easing_curve_evaluator_top.sv @@
`timescale 1ns / 1ps

module tb_easing_curve_evaluator_top;
    import ece_pkg::*;

    localparam logic [63:0] Q31_ONE  = 64'd1 << 31;
    localparam logic [63:0] Q31_HALF = 64'd1 << 30;
    localparam logic [63:0] Q31_FRAC = Q31_ONE - 64'd1;
    localparam logic [63:0] HALF_PI  = 64'hC90FDAA2;
    localparam int          SHIFT    = 31 - FRAC_BITS;
    localparam logic [KIND_W-1:0] KIND_BAD = KIND_LAST + KIND_W'(1);
    localparam int          RANDOM_ITEMS = 740;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [PROG_W-1:0] value;
        logic              err;
    } eased_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [PROG_W-1:0] x;
        bit                typed;
        eased_t            result;
    } row_t;

    logic clk;
    logic rst_n;

    ece_req_if req ();
    ece_rsp_if rsp ();

    easing_curve_evaluator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    eased_t pending_q[$];
    bit     failed;
    int     idle_pct;
    int     stall_pct;
    bit     hold_off;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a >> 31) * b + (((a & Q31_FRAC) * b) >> 31);
    endfunction

    function automatic logic [63:0] quarter_sine(logic [63:0] t);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] v;
        logic [63:0] divs [8];
        divs = '{64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        th = qmul(t, HALF_PI);
        th2 = qmul(th, th);
        v = Q31_ONE;
        for (int i = 0; i < 8; i++)
            v = Q31_ONE - qmul(th2, v) / divs[i];
        v = qmul(th, v);
        return (v > Q31_ONE) ? Q31_ONE : v;
    endfunction

    function automatic logic [63:0] qpow(logic [63:0] b, int n);
        logic [63:0] r;
        r = Q31_ONE;
        for (int i = 0; i < n; i++)
            r = qmul(r, b);
        return r;
    endfunction

    function automatic logic [63:0] smooth_half(logic [KIND_W-1:0] kind, logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] p;
        u2 = qmul(u, u);
        if (kind == KIND_SMOOTH)
            return qmul(3 * Q31_ONE - 2 * u, u2);
        if (kind == KIND_SMOOTH5)
        begin
            p = 10 * Q31_ONE - qmul(15 * Q31_ONE - 6 * u, u);
            return qmul(p, qmul(u2, u));
        end
        p = 70 * Q31_ONE - 20 * u;
        p = 84 * Q31_ONE - qmul(p, u);
        p = 35 * Q31_ONE - qmul(p, u);
        return qmul(p, qmul(u2, u2));
    endfunction

    function automatic logic [63:0] curve_q31(logic [KIND_W-1:0] kind, logic [63:0] t);
        logic [63:0] s;
        logic [63:0] low;
        bit          upper;
        int          k;
        int          n;
        int          d;
        case (kind)
            KIND_LINEAR:
                return t;
            KIND_SMOOTH, KIND_SMOOTH5, KIND_SMOOTH7:
            begin
                upper = t > Q31_HALF;
                low = smooth_half(kind, upper ? Q31_ONE - t : t);
                if (low > Q31_ONE)
                    low = Q31_ONE;
                return upper ? Q31_ONE - low : low;
            end
            KIND_COS_IO:
            begin
                s = quarter_sine(t);
                return qmul(s, s);
            end
            KIND_SIN_IN:
            begin
                s = quarter_sine(t >> 1);
                return 2 * qmul(s, s);
            end
            KIND_SIN_OUT:
                return quarter_sine(t);
            default:
                ;
        endcase
        k = int'(kind) - 7;
        n = 2 + k / 3;
        d = k % 3;
        if (d == 0)
            return qpow(t, n);
        if (d == 1)
            return Q31_ONE - qpow(Q31_ONE - t, n);
        if (t < Q31_HALF)
            return qpow(2 * t, n) >> 1;
        return Q31_ONE - (qpow(2 * (Q31_ONE - t), n) >> 1);
    endfunction

    function automatic eased_t ease(logic [KIND_W-1:0] kind, logic [PROG_W-1:0] x);
        eased_t      r;
        logic [63:0] v;
        r.err = 1'b0;
        r.value = '0;
        if (kind > KIND_LAST || x > ONE_FB)
        begin
            r.err = 1'b1;
            return r;
        end
        if (x == ONE_FB)
            r.value = ONE_FB;
        else if (x != '0)
        begin
            v = curve_q31(kind, 64'(x) << SHIFT);
            if (v > Q31_ONE)
                v = Q31_ONE;
            v = (v + (64'd1 << (SHIFT - 1))) >> SHIFT;
            if (v > 64'(ONE_FB))
                v = 64'(ONE_FB);
            r.value = PROG_W'(v);
        end
        return r;
    endfunction

    task automatic send_request(logic [KIND_W-1:0] kind, logic [PROG_W-1:0] x,
                                bit typed, eased_t result);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.curve_kind <= kind;
        req.progress <= x;
        do
            @(posedge clk);
        while (!req.ready);
        pending_q.push_back(typed ? result : ease(kind, x));
        @(negedge clk);
    endtask

    function automatic logic [KIND_W-1:0] random_kind();
        if ($urandom_range(9) == 0)
            return KIND_W'($urandom_range(31));
        return KIND_W'($urandom_range(int'(KIND_LAST)));
    endfunction

    function automatic logic [PROG_W-1:0] random_progress();
        case ($urandom_range(19))
            0: return '0;
            1: return ONE_FB;
            2: return ONE_FB >> 1;
            3: return PROG_W'($urandom_range(131071));
            4: return PROG_W'($urandom_range(3));
            5: return ONE_FB - PROG_W'($urandom_range(3));
            default: return PROG_W'($urandom_range(int'(ONE_FB)));
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (hold_off)
        begin
            rsp.ready <= 1'b0;
            repeat (300)
                @(negedge clk);
            hold_off = 1'b0;
        end
        rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_q.size() == 0)
            begin
                failed = 1'b1;
                $display("%0t: result with nothing pending: value %0d err %0b", $time,
                         rsp.eased_value, rsp.range_error);
            end
            else
            begin
                if (rsp.eased_value !== pending_q[0].value)
                begin
                    failed = 1'b1;
                    $display("%0t: eased_value expected %0d actual %0d", $time,
                             pending_q[0].value, rsp.eased_value);
                end
                if (rsp.range_error !== pending_q[0].err)
                begin
                    failed = 1'b1;
                    $display("%0t: range_error expected %0b actual %0b", $time,
                             pending_q[0].err, rsp.range_error);
                end
                void'(pending_q.pop_front());
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("easing_curve_evaluator_top verification failed");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        int   pcts [4][2];
        int   waited;

        failed = 1'b0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.curve_kind = '0;
        req.progress = '0;
        rsp.ready = 1'b0;
        pcts = '{'{0, 0}, '{68, 0}, '{0, 68}, '{8, 8}};

        rows.push_back('{KIND_LINEAR, '0, 1, '{'0, 1'b0}});
        rows.push_back('{KIND_SIN_OUT, ONE_FB, 1, '{ONE_FB, 1'b0}});
        rows.push_back('{KIND_SMOOTH7, '0, 1, '{'0, 1'b0}});
        rows.push_back('{KIND_BAD, '0, 1, '{'0, 1'b1}});
        rows.push_back('{KIND_W'(31), ONE_FB, 1, '{'0, 1'b1}});
        rows.push_back('{KIND_W'(9), ONE_FB + PROG_W'(1), 1, '{'0, 1'b1}});
        rows.push_back('{KIND_LINEAR, PROG_W'(131071), 1, '{'0, 1'b1}});
        for (int k = 1; k <= int'(KIND_LAST); k++)
        begin
            r.kind = KIND_W'(k);
            r.x = PROG_W'((k % 2) ? 20000 + k * 700 : 40000 + k * 900);
            r.typed = 0;
            r.result = '0;
            rows.push_back(r);
        end

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_request(rows[i].kind, rows[i].x, rows[i].typed, rows[i].result);

        hold_off = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = pcts[p][0];
            stall_pct = pcts[p][1];
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                send_request(random_kind(), random_progress(), 0, '0);
            if (p == 0)
                for (int i = 0; i < RANDOM_ITEMS / 8; i++)
                    send_request(random_kind(), random_progress(), 0, '0);
        end
        req.valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;

        waited = 0;
        while (pending_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (!failed && pending_q.size() == 0)
            $display("easing_curve_evaluator_top verification clean");
        else
        begin
            if (pending_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_q.size());
            $display("easing_curve_evaluator_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ece_pkg.sv
sv/ece_if.sv
sv/ece_front.sv
sv/ece_cell.sv
sv/ece_out.sv
sv/easing_curve_evaluator_top.sv
verif/tb_easing_curve_evaluator_top.sv
